>>> src/dtd_pkg.sv
package dtd_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_POINT = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam int MANT_W = 31;
  localparam int P10_W  = 30;

  typedef struct packed {
    logic [1:0]        status;
    logic              neg;
    logic [MANT_W-1:0] mant;
    logic [3:0]        frac;
    logic              exp_neg;
    logic [3:0]        exp_val;
    logic              scale;
  } dtd_job_t;

  function automatic logic [P10_W-1:0] pow10(input logic [3:0] n);
    logic [P10_W-1:0] p;
    case (n)
      4'd0: p = 30'd1;
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      4'd9: p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

>>> src/dtd_conv.sv
module dtd_conv
  import dtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dtd_job_t    job,
  output logic        busy,
  output logic        res_valid,
  output logic [63:0] res_bits,
  input  logic        res_ack
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_DIV  = 3'd1;
  localparam logic [2:0] C_MUL  = 3'd2;
  localparam logic [2:0] C_NORM = 3'd3;
  localparam logic [2:0] C_RND  = 3'd4;
  localparam logic [2:0] C_DONE = 3'd5;

  logic [2:0]        state;
  logic [82:0]       w;
  logic signed [11:0] x;
  logic [63:0]       num;
  logic [P10_W-1:0]  rem;
  logic [P10_W-1:0]  dvs;
  logic [P10_W-1:0]  mulr;
  logic [52:0]       sig;
  logic [4:0]        cnt;
  logic              stage;
  logic              sign;
  logic              exp_neg;
  logic [3:0]        exp_val;
  logic              scale;
  logic [63:0]       bits;

  // divide step: one quotient bit a cycle
  logic [P10_W:0] rem2;
  logic           qbit;
  assign rem2 = {rem, num[63]};
  assign qbit = rem2 >= {1'b0, dvs};

  // round to nearest even on w[82:30]
  logic              sticky, inc;
  logic [53:0]       s54;
  logic [52:0]       sig_r;
  logic signed [11:0] xr;
  logic [11:0]       biased;
  assign sticky = (|w[28:0]) | (|rem);
  assign inc    = w[29] & (sticky | w[30]);
  assign s54    = {1'b0, w[82:30]} + {53'd0, inc};
  assign sig_r  = s54[53] ? s54[53:1] : s54[52:0];
  assign xr     = s54[53] ? x + 12'sd31 : x + 12'sd30;
  assign biased = 12'(xr + 12'sd1075);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            sign    <= job.neg;
            exp_neg <= job.exp_neg;
            exp_val <= job.exp_val;
            scale   <= job.scale;
            stage   <= 1'b0;
            rem     <= '0;
            w       <= '0;
            if (job.status != ST_OK) begin
              bits  <= '0;
              state <= C_DONE;
            end else if (job.mant == '0) begin
              bits  <= {job.neg, 63'd0};
              state <= C_DONE;
            end else if (job.frac == 4'd0) begin
              w     <= {52'd0, job.mant};
              x     <= '0;
              state <= C_NORM;
            end else begin
              num   <= {33'd0, job.mant};
              x     <= 12'sd64;
              dvs   <= pow10(job.frac);
              state <= C_DIV;
            end
          end
        end
        C_DIV: begin
          if (w[82]) begin
            state <= C_RND;
          end else begin
            w   <= {w[81:0], qbit};
            rem <= qbit ? P10_W'(rem2 - {1'b0, dvs}) : rem2[P10_W-1:0];
            num <= {num[62:0], 1'b0};
            x   <= x - 12'sd1;
          end
        end
        C_MUL: begin
          w    <= {w[81:0], 1'b0} + (mulr[P10_W-1] ? {30'd0, sig} : 83'd0);
          mulr <= {mulr[P10_W-2:0], 1'b0};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) state <= C_NORM;
        end
        C_NORM: begin
          if (w[82]) begin
            state <= C_RND;
          end else begin
            w <= {w[81:0], 1'b0};
            x <= x - 12'sd1;
          end
        end
        C_RND: begin
          if (!stage && scale) begin
            stage <= 1'b1;
            rem   <= '0;
            w     <= '0;
            if (exp_neg) begin
              num   <= {11'd0, sig_r};
              x     <= xr + 12'sd64;
              dvs   <= pow10(exp_val);
              state <= C_DIV;
            end else begin
              sig   <= sig_r;
              mulr  <= pow10(exp_val);
              x     <= xr;
              cnt   <= 5'd30;
              state <= C_MUL;
            end
          end else begin
            bits  <= {sign, biased[10:0], sig_r[51:0]};
            state <= C_DONE;
          end
        end
        C_DONE: begin
          if (res_ack) state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign busy      = state != C_IDLE;
  assign res_valid = state == C_DONE;
  assign res_bits  = bits;

endmodule

>>> src/decimal_text_to_double.sv
// Decimal string to IEEE double. Characters stream in one per transfer and
// each is parsed combinationally on its transfer, so in_ready stays high through a string.
// The 0 byte ends the string and starts the conversion engine, a shared
// 83-bit shift/add/subtract datapath under a small sequencer; in_ready stays
// low while it runs. With fraction digits it first runs a restoring divide by
// 10^fraction_digits, one quotient bit per cycle until the leading quotient
// bit reaches bit 82; otherwise it normalizes the integer mantissa one bit
// per cycle. A nonzero exponent then adds a shift-add multiply by 10^exponent
// and a normalize for a positive exponent, or a second divide for a negative
// one. Each step ends in a round-to-nearest-even state. An error status or a
// zero mantissa skips the engine and goes straight to the result. Characters
// of the next string are taken while a result still waits on the output.
module decimal_text_to_double
  import dtd_pkg::*;
#(
  parameter int MAX_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value_bits,
  output logic [7:0]  consumed,
  output logic [1:0]  status
);

  localparam int PW = $clog2(MAX_LEN + 1);

  localparam logic [2:0] PH_SIGN  = 3'd0;
  localparam logic [2:0] PH_MANT  = 3'd1;
  localparam logic [2:0] PH_ESIGN = 3'd2;
  localparam logic [2:0] PH_EDIG  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  logic [2:0]        phase, phase_next;
  logic              neg, neg_next;
  logic [MANT_W-1:0] mant, mant_next;
  logic [3:0]        frac, frac_next;
  logic              seen_pt, seen_pt_next;
  logic              eneg, eneg_next;
  logic [3:0]        eval, eval_next;
  logic              ehas, ehas_next;
  logic [PW-1:0]     pos, pos_next;
  logic [PW-1:0]     stop_pos, stop_pos_next;
  logic [1:0]        flags, flags_next;

  logic        conv_busy, res_valid, res_ack, start;
  logic [63:0] res_bits;
  dtd_job_t    job;
  logic [7:0]  pend_cons;
  logic [1:0]  pend_status;

  logic        is_dig, is_sign;
  logic [3:0]  dig;
  logic [35:0] m10;
  logic [6:0]  e10;

  assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign = (ch == CH_MINUS) || (ch == CH_PLUS);
  assign dig     = 4'(ch - CH_ZERO);
  assign m10     = {2'b0, mant, 3'b0} + {4'b0, mant, 1'b0} + {32'd0, dig};
  assign e10     = {eval, 3'b0} + {2'b0, eval, 1'b0} + {3'd0, dig};

  always_comb begin
    phase_next    = phase;
    neg_next      = neg;
    mant_next     = mant;
    frac_next     = frac;
    seen_pt_next  = seen_pt;
    eneg_next     = eneg;
    eval_next     = eval;
    ehas_next     = ehas;
    pos_next      = pos;
    stop_pos_next = stop_pos;
    flags_next    = flags;
    if (phase != PH_DONE) begin
      if (pos >= PW'(MAX_LEN)) begin
        stop_pos_next = pos;
        phase_next    = PH_DONE;
      end else if ((phase == PH_SIGN && is_sign) || (phase == PH_ESIGN && is_sign)) begin
        pos_next = pos + 1'b1;
        if (phase == PH_SIGN) begin
          phase_next = PH_MANT;
          neg_next   = ch == CH_MINUS;
        end else begin
          phase_next = PH_EDIG;
          eneg_next  = ch == CH_MINUS;
        end
      end else if (phase == PH_SIGN || phase == PH_MANT) begin
        phase_next = PH_MANT;
        if (is_dig) begin
          if (m10 > 36'h07FFFFFFF) begin
            flags_next[1] = 1'b1;
            mant_next     = '1;
          end else begin
            mant_next = m10[MANT_W-1:0];
          end
          if (seen_pt) begin
            if (frac != 4'd15) frac_next = frac + 4'd1;
            if (frac >= 4'd9) flags_next[1] = 1'b1;
          end
          pos_next = pos + 1'b1;
        end else if (ch == CH_POINT) begin
          if (seen_pt) begin
            flags_next[0] = 1'b1;
            stop_pos_next = pos;
            phase_next    = PH_DONE;
          end else begin
            seen_pt_next = 1'b1;
            pos_next     = pos + 1'b1;
          end
        end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
          pos_next   = pos + 1'b1;
          phase_next = PH_ESIGN;
        end else begin
          stop_pos_next = pos;
          phase_next    = PH_DONE;
        end
      end else begin
        // exponent digits, also first char after the 'e' when not a sign
        phase_next = PH_EDIG;
        if (is_dig) begin
          if (e10 > 7'd9) begin
            flags_next[1] = 1'b1;
            eval_next     = 4'd10;
          end else begin
            eval_next = e10[3:0];
          end
          ehas_next = 1'b1;
          pos_next  = pos + 1'b1;
        end else begin
          stop_pos_next = pos;
          phase_next    = PH_DONE;
        end
      end
    end
  end

  assign in_ready = !conv_busy;
  assign start    = in_valid && in_ready && (ch == CH_NUL);

  always_comb begin
    job.status  = flags[0] ? ST_POINT : (flags[1] ? ST_OVF : ST_OK);
    job.neg     = neg;
    job.mant    = mant;
    job.frac    = frac;
    job.exp_neg = eneg;
    job.exp_val = eval;
    job.scale   = ehas && (eval != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SIGN;
      neg      <= 1'b0;
      mant     <= '0;
      frac     <= '0;
      seen_pt  <= 1'b0;
      eneg     <= 1'b0;
      eval     <= '0;
      ehas     <= 1'b0;
      pos      <= '0;
      stop_pos <= '0;
      flags    <= '0;
    end else if (start) begin
      pend_cons   <= 8'((phase == PH_DONE) ? stop_pos : pos);
      pend_status <= job.status;
      phase       <= PH_SIGN;
      neg         <= 1'b0;
      mant        <= '0;
      frac        <= '0;
      seen_pt     <= 1'b0;
      eneg        <= 1'b0;
      eval        <= '0;
      ehas        <= 1'b0;
      pos         <= '0;
      stop_pos    <= '0;
      flags       <= '0;
    end else if (in_valid && in_ready) begin
      phase    <= phase_next;
      neg      <= neg_next;
      mant     <= mant_next;
      frac     <= frac_next;
      seen_pt  <= seen_pt_next;
      eneg     <= eneg_next;
      eval     <= eval_next;
      ehas     <= ehas_next;
      pos      <= pos_next;
      stop_pos <= stop_pos_next;
      flags    <= flags_next;
    end
  end

  dtd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .job       (job),
    .busy      (conv_busy),
    .res_valid (res_valid),
    .res_bits  (res_bits),
    .res_ack   (res_ack)
  );

  assign res_ack = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid  <= 1'b1;
      value_bits <= res_bits;
      consumed   <= pend_cons;
      status     <= pend_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/dtd_check.sv
module dtd_check
  import dtd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  ch,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value_bits,
  input logic [7:0]  consumed,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_bits) && $stable(consumed)
      && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_POINT || status == ST_OVF) |-> value_bits == 64'd0)
    else $error("error status with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_POINT || status == ST_OVF)
    else $error("bad status code");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && ch == CH_NUL |=> !in_ready)
    else $error("input taken during conversion");

endmodule

bind decimal_text_to_double dtd_check u_dtd_check (.*);
